FILE: src/clz_pkg.sv
package clz_pkg;

	localparam int HIST_DEPTH = 65536;
	localparam int HIST_AW = 16;
	localparam int CELL_SIDE = 8;
	localparam int CELL_DEPTH = CELL_SIDE * CELL_SIDE;
	localparam int CELL_AW = 6;
	localparam int MAX_OUT_BYTES_DEF = 16777216;
	localparam int CAP_W = 25;

	localparam logic [24:0] CAP_RESET = 25'd16777216;

	localparam logic [2:0] STAT_WRITE = 3'd0;
	localparam logic [2:0] STAT_DONE = 3'd1;
	localparam logic [2:0] STAT_BAD_NDIM = 3'd2;
	localparam logic [2:0] STAT_BAD_SIZE = 3'd3;
	localparam logic [2:0] STAT_BAD_TOKEN = 3'd4;
	localparam logic [2:0] STAT_TRUNC = 3'd5;
	localparam logic [2:0] STAT_BAD_REF = 3'd6;

	localparam logic [7:0] TOK_LIT = 8'h00;
	localparam logic [7:0] TOK_COPY = 8'hC0;
	localparam logic [7:0] TOK_FILL = 8'h40;
	localparam logic [4:0] TAG_TRIPLE = 5'd21;
	localparam logic [4:0] TAG_PAIR = 5'd17;
	localparam logic [7:0] NDIM_2D = 8'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [23:0] out_address;
		logic [7:0]  out_value;
		logic [2:0]  status;
		logic        run_last;
	} out_item_t;

endpackage

FILE: src/cell_lz_2d_decoder.sv
// Streaming decoder for a 2D block coded as 8x8 cells. Bytes enter on in_data, one item per
// byte; each finished cell leaves on out_data as addressed byte writes, the last of which may
// carry the done or truncation status, and status-only items report errors, an empty block
// and a stream cut short. Each byte is accepted in S_IDLE and passes through S_END before the
// next byte is taken. The size check after the header uses a registered product (S_MUL, then
// S_CHK). A copy token moves bytes one a cycle from the 64 KiB history memory into the cell
// buffer, the history read port setting that pace. Every emitted write takes a cell buffer
// read and then a load of the output register, which waits out any output stall.
module cell_lz_2d_decoder #(
	parameter int MAX_OUT_BYTES = clz_pkg::MAX_OUT_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  clz_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output clz_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [24:0]        cfg_data
);

	localparam logic [2:0] PH_NDIM = 3'd0;
	localparam logic [2:0] PH_ROWS = 3'd1;
	localparam logic [2:0] PH_COLS = 3'd2;
	localparam logic [2:0] PH_TOKEN = 3'd3;
	localparam logic [2:0] PH_OFF = 3'd4;
	localparam logic [2:0] PH_FILL = 3'd5;
	localparam logic [2:0] PH_LIT = 3'd6;
	localparam logic [2:0] PH_STOP = 3'd7;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL = 3'd1;
	localparam logic [2:0] S_CHK = 3'd2;
	localparam logic [2:0] S_COPY = 3'd3;
	localparam logic [2:0] S_EMIT_RD = 3'd4;
	localparam logic [2:0] S_EMIT_WR = 3'd5;
	localparam logic [2:0] S_FAIL = 3'd6;
	localparam logic [2:0] S_END = 3'd7;

	localparam logic [24:0] CAP_MAX = 25'(MAX_OUT_BYTES);

	logic [2:0]  st_q;
	logic [2:0]  phase_q;
	logic [24:0] cap_q;
	logic [31:0] pos_q;
	logic [31:0] rows_q;
	logic [31:0] cols_q;
	logic [21:0] lastr_q;
	logic [21:0] lastc_q;
	logic [21:0] row_idx_q;
	logic [21:0] col_idx_q;
	logic [23:0] cellrow_base_q;
	logic [23:0] rowaddr_q;
	logic [6:0]  cnt_q;
	logic [7:0]  tok_q;
	logic [7:0]  off_lo_q;
	logic        fin_q;
	logic        emitted_q;
	logic        use_fill_q;
	logic [7:0]  fill_q;
	logic [2:0]  code_q;
	logic [3:0]  a_q;
	logic [3:0]  c_q;
	logic [5:0]  e_q;
	logic [15:0] src_q;
	logic [5:0]  dst_q;
	logic [6:0]  len_q;
	logic [6:0]  k_q;
	logic        rd_valid_s1;
	logic [5:0]  wr_idx_s1;
	logic [61:0] prod_q;
	logic        out_valid_q;
	clz_pkg::out_item_t out_q;

	logic        acc;
	logic        slot_free;
	logic [7:0]  b;
	logic [3:0]  h;
	logic [3:0]  w;
	logic [6:0]  hw;
	logic        triple;
	logic [2:0]  first_row;
	logic [3:0]  rr_adj;
	logic [5:0]  lit_slot;
	logic [6:0]  lit_need;
	logic [6:0]  cnt_inc;
	logic [15:0] off_full;
	logic [6:0]  copy_len;
	logic        ref_bad;
	logic [23:0] cell_start;
	logic        last_el;
	logic        cell_done;
	logic [24:0] cap_eff;

	logic        hist_we;
	logic        hist_re;
	logic [15:0] hist_raddr;
	logic [7:0]  hist_rdata;
	logic        cb_we;
	logic [5:0]  cb_waddr;
	logic [7:0]  cb_wdata;
	logic        cb_re;
	logic [7:0]  cb_rdata;

	assign in_ready = (st_q == S_IDLE);
	assign acc = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign slot_free = !out_valid_q || out_ready;
	assign b = in_data.in_byte;

	// extent of the current cell, clipped at the last row and column
	assign h = (row_idx_q == lastr_q && rows_q[2:0] != 3'd0) ? {1'b0, rows_q[2:0]} : 4'd8;
	assign w = (col_idx_q == lastc_q && cols_q[2:0] != 3'd0) ? {1'b0, cols_q[2:0]} : 4'd8;
	assign hw = {3'b0, h} * {3'b0, w};

	assign triple = (tok_q[7:3] == clz_pkg::TAG_TRIPLE);
	assign first_row = tok_q[2:0];
	assign rr_adj = ({1'b0, cnt_q[5:3]} >= {1'b0, first_row})
		? ({1'b0, cnt_q[5:3]} + (triple ? 4'd3 : 4'd2)) : {1'b0, cnt_q[5:3]};
	assign lit_slot = (tok_q == clz_pkg::TOK_LIT) ? cnt_q[5:0] : {rr_adj[2:0], cnt_q[2:0]};
	assign lit_need = (tok_q == clz_pkg::TOK_LIT) ? hw : (triple ? 7'd40 : 7'd48);
	assign cnt_inc = cnt_q + 7'd1;

	assign off_full = {b, off_lo_q};
	assign copy_len = (tok_q == clz_pkg::TOK_COPY) ? hw : (triple ? 7'd24 : 7'd16);
	assign ref_bad = (off_full < {9'b0, copy_len}) || (off_full > 16'd65534)
		|| (pos_q < ({16'b0, off_full} + 32'd2));

	assign cell_start = cellrow_base_q + {col_idx_q[20:0], 3'b0};
	assign last_el = (a_q == h - 4'd1) && (c_q == w - 4'd1);
	assign cell_done = (col_idx_q == lastc_q) && (row_idx_q == lastr_q);
	assign cap_eff = (cap_q > CAP_MAX) ? CAP_MAX : cap_q;

	assign hist_we = acc && (phase_q != PH_STOP);
	assign hist_re = (st_q == S_COPY) && (k_q < len_q);
	assign hist_raddr = src_q + {9'b0, k_q};

	assign cb_we = (acc && phase_q == PH_LIT) || rd_valid_s1;
	assign cb_waddr = rd_valid_s1 ? wr_idx_s1 : lit_slot;
	assign cb_wdata = rd_valid_s1 ? hist_rdata : b;
	assign cb_re = (st_q == S_EMIT_RD);

	clz_ram #(
		.DEPTH(clz_pkg::HIST_DEPTH),
		.WIDTH(8)
	) u_hist (
		.clk(clk),
		.we(hist_we),
		.waddr(pos_q[clz_pkg::HIST_AW-1:0]),
		.wdata(b),
		.re(hist_re),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	clz_ram #(
		.DEPTH(clz_pkg::CELL_DEPTH),
		.WIDTH(8)
	) u_cbuf (
		.clk(clk),
		.we(cb_we),
		.waddr(cb_waddr),
		.wdata(cb_wdata),
		.re(cb_re),
		.raddr(e_q),
		.rdata(cb_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			phase_q <= PH_NDIM;
			cap_q <= clz_pkg::CAP_RESET;
			pos_q <= '0;
			rows_q <= '0;
			cols_q <= '0;
			lastr_q <= '0;
			lastc_q <= '0;
			row_idx_q <= '0;
			col_idx_q <= '0;
			cellrow_base_q <= '0;
			cnt_q <= '0;
			tok_q <= '0;
			off_lo_q <= '0;
			fin_q <= 1'b0;
			emitted_q <= 1'b0;
			use_fill_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_valid_s1 <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (acc) begin
						fin_q <= in_data.in_last;
						emitted_q <= 1'b0;
						if (phase_q != PH_STOP && pos_q != 32'hFFFF_FFFF) begin
							pos_q <= pos_q + 32'd1;
						end
						st_q <= S_END;
						case (phase_q)
							PH_NDIM: begin
								cnt_q <= '0;
								if (b != clz_pkg::NDIM_2D) begin
									code_q <= clz_pkg::STAT_BAD_NDIM;
									st_q <= S_FAIL;
								end else begin
									phase_q <= PH_ROWS;
								end
							end
							PH_ROWS: begin
								rows_q <= rows_q | ({24'b0, b} << {cnt_q[1:0], 3'b0});
								cnt_q <= cnt_inc;
								if (cnt_q == 7'd3) begin
									cnt_q <= '0;
									phase_q <= PH_COLS;
								end
							end
							PH_COLS: begin
								cols_q <= cols_q | ({24'b0, b} << {cnt_q[1:0], 3'b0});
								cnt_q <= cnt_inc;
								if (cnt_q == 7'd3) begin
									st_q <= S_MUL;
								end
							end
							PH_TOKEN: begin
								tok_q <= b;
								cnt_q <= '0;
								if (b == clz_pkg::TOK_LIT) begin
									phase_q <= PH_LIT;
								end else if (b == clz_pkg::TOK_COPY) begin
									phase_q <= PH_OFF;
								end else if (b == clz_pkg::TOK_FILL) begin
									phase_q <= PH_FILL;
								end else if (b[7:3] == clz_pkg::TAG_TRIPLE && b[2:0] <= 3'd5) begin
									phase_q <= PH_OFF;
								end else if (b[7:3] == clz_pkg::TAG_PAIR && b[2:0] <= 3'd6) begin
									phase_q <= PH_OFF;
								end else begin
									code_q <= clz_pkg::STAT_BAD_TOKEN;
									st_q <= S_FAIL;
								end
							end
							PH_OFF: begin
								if (cnt_q == 7'd0) begin
									off_lo_q <= b;
									cnt_q <= 7'd1;
								end else if (ref_bad) begin
									code_q <= clz_pkg::STAT_BAD_REF;
									st_q <= S_FAIL;
								end else begin
									cnt_q <= '0;
									src_q <= pos_q[15:0] - 16'd2 - off_full;
									dst_q <= (tok_q == clz_pkg::TOK_COPY) ? 6'd0
										: {tok_q[2:0], 3'b0};
									len_q <= copy_len;
									k_q <= '0;
									st_q <= S_COPY;
								end
							end
							PH_FILL: begin
								fill_q <= b;
								use_fill_q <= 1'b1;
								a_q <= '0;
								c_q <= '0;
								e_q <= '0;
								rowaddr_q <= cell_start;
								st_q <= S_EMIT_RD;
							end
							PH_LIT: begin
								cnt_q <= cnt_inc;
								if (cnt_inc >= lit_need) begin
									use_fill_q <= 1'b0;
									a_q <= '0;
									c_q <= '0;
									e_q <= '0;
									rowaddr_q <= cell_start;
									st_q <= S_EMIT_RD;
								end
							end
							default: begin
								// stopped: drop the byte
							end
						endcase
					end
				end
				S_MUL: begin
					prod_q <= rows_q[30:0] * cols_q[30:0];
					lastr_q <= 22'(((rows_q + 32'd7) >> 3) - 32'd1);
					lastc_q <= 22'(((cols_q + 32'd7) >> 3) - 32'd1);
					st_q <= S_CHK;
				end
				S_CHK: begin
					row_idx_q <= '0;
					col_idx_q <= '0;
					cellrow_base_q <= '0;
					cnt_q <= '0;
					st_q <= S_END;
					if (rows_q[31] || cols_q[31] || prod_q > {37'b0, cap_eff}) begin
						code_q <= clz_pkg::STAT_BAD_SIZE;
						st_q <= S_FAIL;
					end else if (prod_q == '0) begin
						code_q <= clz_pkg::STAT_DONE;
						st_q <= S_FAIL;
					end else begin
						phase_q <= PH_TOKEN;
					end
				end
				S_COPY: begin
					rd_valid_s1 <= hist_re;
					wr_idx_s1 <= dst_q + k_q[5:0];
					if (hist_re) begin
						k_q <= k_q + 7'd1;
					end else if (!rd_valid_s1) begin
						cnt_q <= '0;
						if (tok_q == clz_pkg::TOK_COPY) begin
							use_fill_q <= 1'b0;
							a_q <= '0;
							c_q <= '0;
							e_q <= '0;
							rowaddr_q <= cell_start;
							st_q <= S_EMIT_RD;
						end else begin
							phase_q <= PH_LIT;
							st_q <= S_END;
						end
					end
				end
				S_EMIT_RD: begin
					st_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						emitted_q <= 1'b1;
						out_q.out_address <= rowaddr_q + {20'b0, c_q};
						out_q.out_value <= use_fill_q ? fill_q : cb_rdata;
						out_q.run_last <= last_el;
						out_q.status <= clz_pkg::STAT_WRITE;
						if (!last_el) begin
							e_q <= e_q + 6'd1;
							st_q <= S_EMIT_RD;
							if (c_q == w - 4'd1) begin
								c_q <= '0;
								a_q <= a_q + 4'd1;
								rowaddr_q <= rowaddr_q + cols_q[23:0];
							end else begin
								c_q <= c_q + 4'd1;
							end
						end else begin
							cnt_q <= '0;
							st_q <= S_END;
							phase_q <= PH_TOKEN;
							if (cell_done) begin
								out_q.status <= clz_pkg::STAT_DONE;
							end else if (fin_q) begin
								out_q.status <= clz_pkg::STAT_TRUNC;
							end
							if (col_idx_q == lastc_q) begin
								col_idx_q <= '0;
								if (row_idx_q == lastr_q) begin
									phase_q <= PH_STOP;
								end else begin
									row_idx_q <= row_idx_q + 22'd1;
									cellrow_base_q <= cellrow_base_q + {cols_q[20:0], 3'b0};
								end
							end else begin
								col_idx_q <= col_idx_q + 22'd1;
							end
						end
					end
				end
				S_FAIL: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						emitted_q <= 1'b1;
						out_q.out_address <= '0;
						out_q.out_value <= '0;
						out_q.status <= code_q;
						out_q.run_last <= 1'b1;
						phase_q <= PH_STOP;
						st_q <= S_END;
					end
				end
				S_END: begin
					if (fin_q && phase_q != PH_STOP && !emitted_q) begin
						if (slot_free) begin
							out_valid_q <= 1'b1;
							emitted_q <= 1'b1;
							out_q.out_address <= '0;
							out_q.out_value <= '0;
							out_q.status <= clz_pkg::STAT_TRUNC;
							out_q.run_last <= 1'b1;
						end
					end else begin
						st_q <= S_IDLE;
						if (fin_q) begin
							// restart for a fresh stream
							pos_q <= '0;
							rows_q <= '0;
							cols_q <= '0;
							row_idx_q <= '0;
							col_idx_q <= '0;
							cellrow_base_q <= '0;
							phase_q <= PH_NDIM;
							tok_q <= '0;
							off_lo_q <= '0;
							cnt_q <= '0;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/clz_ram.sv
module clz_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/clz_checker.sv
module clz_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input clz_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != clz_pkg::STAT_WRITE
			&& out_data.status != clz_pkg::STAT_DONE
			&& out_data.status != clz_pkg::STAT_TRUNC
		|-> out_data.out_address == '0 && out_data.out_value == '0)
		else $error("error item carries address or value");

	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != clz_pkg::STAT_WRITE |-> out_data.run_last)
		else $error("status item not last of its run");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= clz_pkg::STAT_BAD_REF)
		else $error("status code out of range");

endmodule

bind cell_lz_2d_decoder clz_checker u_clz_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
